[rtl/bole_pkg.sv]
// Shared types and codes for the bounded ordered list engine.
// No dependencies; used by bole_ctrl and bounded_ordered_list_engine_top.
package bole_pkg;

    localparam logic [2:0] REQ_INS_FRONT = 3'd0;
    localparam logic [2:0] REQ_INS_END   = 3'd1;
    localparam logic [2:0] REQ_INS_POS   = 3'd2;
    localparam logic [2:0] REQ_DEL_FRONT = 3'd3;
    localparam logic [2:0] REQ_DEL_END   = 3'd4;
    localparam logic [2:0] REQ_DEL_POS   = 3'd5;
    localparam logic [2:0] REQ_SEARCH    = 3'd6;
    localparam logic [2:0] REQ_REVERSE   = 3'd7;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_EMPTY  = 2'd1;
    localparam logic [1:0] STAT_BADPOS = 2'd2;
    localparam logic [1:0] STAT_FULL   = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] removed;
        logic        found;
        logic [4:0]  fpos;
        logic [5:0]  total;
    } bole_res_t;

endpackage

[rtl/bole_ram.sv]
// Single-port-write, single-port-read synchronous RAM holding the list entries.
// Read data is registered. No dependencies.
module bole_ram #(
    parameter int AW = 5,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/bole_ctrl.sv]
// Request sequencer: circular list addressing (base, direction), entry walks
// through the RAM for shifts and search. Depends on bole_pkg.
module bole_ctrl #(
    parameter int LIST_DEPTH = 32,
    parameter int AW = 5,
    parameter int CW = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          req_type,
    input  logic [31:0]         value,
    input  logic [5:0]          position,
    output logic                res_valid,
    input  logic                out_free,
    output bole_pkg::bole_res_t res,
    output logic                mem_we,
    output logic [AW-1:0]       mem_waddr,
    output logic [31:0]         mem_wdata,
    output logic                mem_re,
    output logic [AW-1:0]       mem_raddr,
    input  logic [31:0]         mem_rdata
);

    localparam int PW = (CW > 6) ? CW : 6;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RUN   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_TAIL  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] base_reg, base_next;
    logic          dir_reg, dir_next;
    logic [CW-1:0] count_reg, count_next;
    logic [2:0]    kind_reg, kind_next;
    logic [31:0]   val_reg, val_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] jend_reg, jend_next;
    logic          down_reg, down_next;
    logic          first_reg, first_next;
    logic          pend_reg, pend_next;
    logic          pfirst_reg, pfirst_next;
    logic [CW-1:0] pidx_reg, pidx_next;
    logic [AW-1:0] pdst_reg, pdst_next;
    logic [1:0]    stat_reg, stat_next;
    logic [31:0]   rem_reg, rem_next;
    logic          fnd_reg, fnd_next;
    logic [CW-1:0] fpos_reg, fpos_next;

    logic [PW-1:0] pos_w;
    logic [PW-1:0] count_w;
    logic          full;
    logic          empty;

    // logical position to RAM address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic dir,
                                           input logic [CW-1:0] idx);
        logic [AW-1:0] off;
        off = idx[AW-1:0];
        return dir ? (base - off) : (base + off);
    endfunction

    assign pos_w   = PW'(position);
    assign count_w = PW'(count_reg);
    assign full    = (count_reg == CW'(LIST_DEPTH));
    assign empty   = (count_reg == '0);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_FIN);

    assign res.status  = stat_reg;
    assign res.removed = rem_reg;
    assign res.found   = fnd_reg;
    assign res.fpos    = 5'(fpos_reg);
    assign res.total   = 6'(count_reg);

    always_comb
    begin
        state_next  = state_reg;
        base_next   = base_reg;
        dir_next    = dir_reg;
        count_next  = count_reg;
        kind_next   = kind_reg;
        val_next    = val_reg;
        pos_next    = pos_reg;
        j_next      = j_reg;
        jend_next   = jend_reg;
        down_next   = down_reg;
        first_next  = first_reg;
        pend_next   = 1'b0;
        pfirst_next = pfirst_reg;
        pidx_next   = pidx_reg;
        pdst_next   = pdst_reg;
        stat_next   = stat_reg;
        rem_next    = rem_reg;
        fnd_next    = fnd_reg;
        fpos_next   = fpos_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = val_reg;
        mem_re      = 1'b0;
        mem_raddr   = phys(base_reg, dir_reg, j_reg);

        // retire the entry read in the previous cycle
        if (pend_reg)
        begin
            case (kind_reg)
                bole_pkg::REQ_SEARCH:
                begin
                    if (!fnd_reg && (mem_rdata == val_reg))
                    begin
                        fnd_next  = 1'b1;
                        fpos_next = pidx_reg;
                    end
                end
                default:
                begin
                    if (pfirst_reg)
                    begin
                        rem_next = mem_rdata;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = pdst_reg;
                        mem_wdata = mem_rdata;
                    end
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = req_type;
                    val_next   = value;
                    pos_next   = CW'(pos_w);
                    stat_next  = bole_pkg::STAT_OK;
                    rem_next   = '0;
                    fnd_next   = 1'b0;
                    fpos_next  = '0;
                    first_next = 1'b1;
                    down_next  = 1'b0;
                    j_next     = '0;
                    jend_next  = count_reg - CW'(1);
                    state_next = S_FIN;
                    unique case (req_type)
                        bole_pkg::REQ_INS_FRONT:
                        begin
                            if (full)
                            begin
                                stat_next = bole_pkg::STAT_FULL;
                            end
                            else
                            begin
                                base_next  = dir_reg ? (base_reg + AW'(1)) : (base_reg - AW'(1));
                                mem_we     = 1'b1;
                                mem_waddr  = base_next;
                                mem_wdata  = value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        bole_pkg::REQ_INS_END:
                        begin
                            if (full)
                            begin
                                stat_next = bole_pkg::STAT_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = phys(base_reg, dir_reg, count_reg);
                                mem_wdata  = value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        bole_pkg::REQ_INS_POS:
                        begin
                            if (pos_w > count_w)
                            begin
                                stat_next = bole_pkg::STAT_BADPOS;
                            end
                            else if (full)
                            begin
                                stat_next = bole_pkg::STAT_FULL;
                            end
                            else if (pos_w == count_w)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = phys(base_reg, dir_reg, count_reg);
                                mem_wdata  = value;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                // shift the tail up, last entry first
                                j_next     = count_reg - CW'(1);
                                jend_next  = CW'(pos_w);
                                down_next  = 1'b1;
                                first_next = 1'b0;
                                state_next = S_RUN;
                            end
                        end
                        bole_pkg::REQ_DEL_FRONT:
                        begin
                            if (empty)
                            begin
                                stat_next = bole_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                jend_next  = '0;
                                state_next = S_RUN;
                            end
                        end
                        bole_pkg::REQ_DEL_END:
                        begin
                            if (empty)
                            begin
                                stat_next = bole_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                j_next     = count_reg - CW'(1);
                                state_next = S_RUN;
                            end
                        end
                        bole_pkg::REQ_DEL_POS:
                        begin
                            if (empty)
                            begin
                                stat_next = bole_pkg::STAT_EMPTY;
                            end
                            else if (pos_w >= count_w)
                            begin
                                stat_next = bole_pkg::STAT_BADPOS;
                            end
                            else
                            begin
                                j_next     = CW'(pos_w);
                                state_next = S_RUN;
                            end
                        end
                        bole_pkg::REQ_SEARCH:
                        begin
                            if (empty)
                            begin
                                stat_next = bole_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = S_RUN;
                            end
                        end
                        bole_pkg::REQ_REVERSE:
                        begin
                            if (!empty)
                            begin
                                base_next = phys(base_reg, dir_reg, count_reg - CW'(1));
                                dir_next  = !dir_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                mem_re      = 1'b1;
                pend_next   = 1'b1;
                pfirst_next = first_reg;
                first_next  = 1'b0;
                pidx_next   = j_reg;
                pdst_next   = phys(base_reg, dir_reg,
                                   down_reg ? (j_reg + CW'(1)) : (j_reg - CW'(1)));
                if (j_reg == jend_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    j_next = down_reg ? (j_reg - CW'(1)) : (j_reg + CW'(1));
                end
            end
            S_DRAIN:
            begin
                state_next = S_TAIL;
            end
            S_TAIL:
            begin
                state_next = S_FIN;
                case (kind_reg) inside
                    bole_pkg::REQ_INS_POS:
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = phys(base_reg, dir_reg, pos_reg);
                        mem_wdata  = val_reg;
                        count_next = count_reg + CW'(1);
                    end
                    bole_pkg::REQ_DEL_FRONT:
                    begin
                        base_next  = phys(base_reg, dir_reg, CW'(1));
                        count_next = count_reg - CW'(1);
                    end
                    bole_pkg::REQ_DEL_END, bole_pkg::REQ_DEL_POS:
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            base_reg  <= '0;
            dir_reg   <= 1'b0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
            dir_reg   <= dir_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        val_reg    <= val_next;
        pos_reg    <= pos_next;
        j_reg      <= j_next;
        jend_reg   <= jend_next;
        down_reg   <= down_next;
        first_reg  <= first_next;
        pfirst_reg <= pfirst_next;
        pidx_reg   <= pidx_next;
        pdst_reg   <= pdst_next;
        stat_reg   <= stat_next;
        rem_reg    <= rem_next;
        fnd_reg    <= fnd_next;
        fpos_reg   <= fpos_next;
    end

endmodule

[rtl/bounded_ordered_list_engine_top.sv]
// Top level of the bounded ordered list engine: sequencer, entry RAM, result register.
// Depends on bole_pkg, bole_ram, bole_ctrl.
//
// channel   signals                                    direction
// in        in_valid/in_ready, req_type value position  request in
// out       out_valid/out_ready, status removed_value   result out
//           found found_position entry_total
//
// Insert at front or end, insert at the end position, refused requests and reverse
// go from idle straight to the result state. Deletes, positional insert and search
// walk the entries through S_RUN, S_DRAIN and S_TAIL before the result: the walk
// reads one RAM entry per cycle (single read port), then drains.
// Reset clears the state, base, direction and count; the RAM holds no reset state. A stalled result waits
// in the output register while the next request is already accepted.
module bounded_ordered_list_engine_top #(
    parameter int LIST_DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] value,
    input  logic [5:0]         position,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [31:0] removed_value,
    output logic               found,
    output logic [4:0]         found_position,
    output logic [5:0]         entry_total
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    bole_pkg::bole_res_t res;
    bole_pkg::bole_res_t out_reg;
    logic                out_valid_reg;
    logic                res_valid;
    logic                out_free;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [31:0]         mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [31:0]         mem_rdata;

    assign out_free = !out_valid_reg || out_ready;

    bole_ctrl #(
        .LIST_DEPTH(LIST_DEPTH),
        .AW(AW),
        .CW(CW)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .req_type(req_type),
        .value(value),
        .position(position),
        .res_valid(res_valid),
        .out_free(out_free),
        .res(res),
        .mem_we(mem_we),
        .mem_waddr(mem_waddr),
        .mem_wdata(mem_wdata),
        .mem_re(mem_re),
        .mem_raddr(mem_raddr),
        .mem_rdata(mem_rdata)
    );

    bole_ram #(
        .AW(AW),
        .DW(32)
    ) u_ram (
        .clk(clk),
        .we(mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re(mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_reg.status;
    assign removed_value  = out_reg.removed;
    assign found          = out_reg.found;
    assign found_position = out_reg.fpos;
    assign entry_total    = out_reg.total;

    a_res_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && out_free |=> out_valid)
        else $error("result not loaded into output register");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != bole_pkg::STAT_OK) |-> (removed_value == 0) && !found)
        else $error("refused request carries data");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> (status == bole_pkg::STAT_OK) && (found_position == 5'(found_position)))
        else $error("hit reported with bad status");

    a_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !in_ready)
        else $error("request accepted while result pending in sequencer");

endmodule
